FILE: design/mva_pkg.sv
// Shared types and constants for the MIDI voice allocator.
package mva_pkg;

  localparam int VOICES      = 18;
  localparam int AGE_BITS    = 32;
  localparam int VOICE_IDX_W = 5;
  localparam int CHAN_W      = 5;
  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 7;
  localparam int OP_W        = 2;

  localparam logic [CHAN_W-1:0] CHANNEL_MAX = CHAN_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_CHAN_OFF = 2'd2,
    OP_ALL_OFF  = 2'd3
  } mva_op_t;

  typedef logic [VOICE_IDX_W-1:0] voice_idx_t;
  typedef logic [AGE_BITS-1:0]    age_t;
  typedef logic [VOICES-1:0]      voice_mask_t;

  // One voice slot as seen by the scan.
  typedef struct packed {
    logic              busy;
    logic [NOTE_W-1:0] note;
    logic [CHAN_W-1:0] channel;
    age_t              age;
  } voice_entry_t;

  // Update request to the voice table: key on (set) or key off (clear).
  typedef struct packed {
    logic              set_en;
    logic              clr_en;
    voice_idx_t        idx;
    logic [NOTE_W-1:0] note;
    logic [CHAN_W-1:0] channel;
    age_t              age;
  } table_cmd_t;

endpackage

FILE: design/mva_in_if.sv
// Event channel: one MIDI event per beat.
interface mva_in_if;
  logic                       valid;
  logic                       ready;
  logic [mva_pkg::OP_W-1:0]   operation;
  logic [mva_pkg::CHAN_W-1:0] midi_channel;
  logic [mva_pkg::NOTE_W-1:0] note_number;
  logic [mva_pkg::VEL_W-1:0]  velocity;

  modport source (output valid, operation, midi_channel, note_number, velocity,
                  input ready);
  modport sink   (input valid, operation, midi_channel, note_number, velocity,
                  output ready);
endinterface

FILE: design/mva_out_if.sv
// Result channel: one allocation result per beat.
interface mva_out_if;
  logic                            valid;
  logic                            ready;
  logic                            assigned_valid;
  logic [mva_pkg::VOICE_IDX_W-1:0] assigned_voice;
  logic                            voice_stolen;
  logic [mva_pkg::VOICES-1:0]      released_mask;

  modport source (output valid, assigned_valid, assigned_voice, voice_stolen,
                  released_mask, input ready);
  modport sink   (input valid, assigned_valid, assigned_voice, voice_stolen,
                  released_mask, output ready);
endinterface

FILE: design/midi_voice_allocator_unit.sv
// Top level of the MIDI voice allocator: event sequencer and voice scan.
//
//  channel | dir | beat content
//  --------+-----+-------------------------------------------------------
//  in_ch   | in  | operation, midi_channel, note_number, velocity
//  out_ch  | out | assigned_valid, assigned_voice, voice_stolen, released_mask
//
// A note on passes through accept, a scan of every voice, commit and result;
// the result holds until it is taken. A key-off event skips the commit.
// The voice scan reads one table slot per cycle and runs it through a single
// shared age comparator and match logic.
// An event on an invalid channel (other than all notes off) skips the scan.
// Synchronous active-low reset frees all voices and clears the age counter.
// in_ch.ready is high only while idle; a stalled result holds until taken.
module midi_voice_allocator_unit (
  input  logic      clk,
  input  logic      rst_n,
  mva_in_if.sink    in_ch,
  mva_out_if.source out_ch
);
  import mva_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_OUT
  } state_t;

  // Control
  state_t     state_r, state_nxt;
  voice_idx_t idx_r, idx_nxt;
  age_t       age_ctr_r, age_ctr_nxt;
  logic       free_found_r, free_found_nxt;

  // Latched event and scan results
  mva_op_t           op_r, op_nxt;
  logic [CHAN_W-1:0] ch_r, ch_nxt;
  logic [NOTE_W-1:0] note_r, note_nxt;
  voice_mask_t       mask_r, mask_nxt;
  voice_idx_t        free_idx_r, free_idx_nxt;
  voice_idx_t        best_idx_r, best_idx_nxt;
  age_t              best_age_r, best_age_nxt;

  // Result registers
  logic        out_assigned_r, out_assigned_nxt;
  voice_idx_t  out_voice_r, out_voice_nxt;
  logic        out_stolen_r, out_stolen_nxt;
  voice_mask_t out_mask_r, out_mask_nxt;

  voice_entry_t ent;
  table_cmd_t   cmd;

  mva_op_t    in_op;
  logic       in_ch_ok;
  logic       hit;
  logic       age_lt;
  logic       last_voice;
  voice_idx_t pick;

  mva_voice_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r),
    .rd_entry (ent),
    .cmd      (cmd)
  );

  // Note on with zero velocity is a note off.
  always_comb begin
    in_op = mva_op_t'(in_ch.operation);
    if (in_op == OP_NOTE_ON && in_ch.velocity == '0) begin
      in_op = OP_NOTE_OFF;
    end
  end

  assign in_ch_ok   = (in_ch.midi_channel != '0) && (in_ch.midi_channel <= CHANNEL_MAX);
  assign last_voice = (idx_r == VOICE_IDX_W'(VOICES - 1));

  // Shared age comparator: oldest voice, strict less keeps the lowest index.
  assign age_lt = (ent.age < best_age_r);

  // Key-off match for the slot under the scan.
  always_comb begin
    hit = 1'b0;
    case (op_r)
      OP_ALL_OFF:  hit = ent.busy;
      OP_CHAN_OFF: hit = ent.busy && (ent.channel == ch_r);
      OP_NOTE_OFF: hit = ent.busy && (ent.channel == ch_r) && (ent.note == note_r);
      default:     hit = 1'b0;
    endcase
  end

  assign pick = free_found_r ? free_idx_r : best_idx_r;

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    age_ctr_nxt      = age_ctr_r;
    free_found_nxt   = free_found_r;
    op_nxt           = op_r;
    ch_nxt           = ch_r;
    note_nxt         = note_r;
    mask_nxt         = mask_r;
    free_idx_nxt     = free_idx_r;
    best_idx_nxt     = best_idx_r;
    best_age_nxt     = best_age_r;
    out_assigned_nxt = out_assigned_r;
    out_voice_nxt    = out_voice_r;
    out_stolen_nxt   = out_stolen_r;
    out_mask_nxt     = out_mask_r;
    cmd              = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt         = in_op;
          ch_nxt         = in_ch.midi_channel;
          note_nxt       = in_ch.note_number;
          idx_nxt        = '0;
          mask_nxt       = '0;
          free_found_nxt = 1'b0;
          if (in_op != OP_ALL_OFF && !in_ch_ok) begin
            // drop: no state change, all-zero result
            out_assigned_nxt = 1'b0;
            out_voice_nxt    = '0;
            out_stolen_nxt   = 1'b0;
            out_mask_nxt     = '0;
            state_nxt        = ST_OUT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (op_r == OP_NOTE_ON) begin
          // track lowest free slot and oldest slot, busy or not
          if (!ent.busy && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r;
          end
          if (idx_r == '0 || age_lt) begin
            best_idx_nxt = idx_r;
            best_age_nxt = ent.age;
          end
        end else if (hit) begin
          cmd.clr_en = 1'b1;
          cmd.idx    = idx_r;
          mask_nxt   = mask_r | (voice_mask_t'(1) << idx_r);
        end

        if (last_voice) begin
          if (op_r == OP_NOTE_ON) begin
            state_nxt = ST_COMMIT;
          end else begin
            out_assigned_nxt = 1'b0;
            out_voice_nxt    = '0;
            out_stolen_nxt   = 1'b0;
            out_mask_nxt     = mask_nxt;
            state_nxt        = ST_OUT;
          end
        end else begin
          idx_nxt = idx_r + VOICE_IDX_W'(1);
        end
      end

      ST_COMMIT: begin
        age_ctr_nxt      = age_ctr_r + AGE_BITS'(1);
        cmd.set_en       = 1'b1;
        cmd.idx          = pick;
        cmd.note         = note_r;
        cmd.channel      = ch_r;
        cmd.age          = age_ctr_nxt;
        out_assigned_nxt = 1'b1;
        out_voice_nxt    = pick;
        out_stolen_nxt   = !free_found_r;
        out_mask_nxt     = free_found_r ? '0 : (voice_mask_t'(1) << pick);
        state_nxt        = ST_OUT;
      end

      ST_OUT: begin
        // hold the result until the sink takes the beat
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    ch_r           <= ch_nxt;
    note_r         <= note_nxt;
    mask_r         <= mask_nxt;
    free_idx_r     <= free_idx_nxt;
    best_idx_r     <= best_idx_nxt;
    best_age_r     <= best_age_nxt;
    out_assigned_r <= out_assigned_nxt;
    out_voice_r    <= out_voice_nxt;
    out_stolen_r   <= out_stolen_nxt;
    out_mask_r     <= out_mask_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      age_ctr_r    <= '0;
      free_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      age_ctr_r    <= age_ctr_nxt;
      free_found_r <= free_found_nxt;
    end
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = (state_r == ST_OUT);
  assign out_ch.assigned_valid = out_assigned_r;
  assign out_ch.assigned_voice = out_voice_r;
  assign out_ch.voice_stolen   = out_stolen_r;
  assign out_ch.released_mask  = out_mask_r;

`ifndef ASSERT_OFF
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result is pending");

  a_steal_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.voice_stolen) |->
      (out_ch.assigned_valid && $onehot(out_ch.released_mask)))
    else $error("stolen voice without a single released bit");

  a_free_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.assigned_valid && !out_ch.voice_stolen) |->
      (out_ch.released_mask == '0))
    else $error("free voice assignment released voices");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= VOICE_IDX_W'(VOICES - 1))
    else $error("scan index beyond last voice");

  a_age_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_COMMIT) |=> (age_ctr_r == $past(age_ctr_r)))
    else $error("age counter moved outside commit");
`endif

endmodule

FILE: design/mva_voice_table.sv
// Per-voice state: busy flags plus note, channel and start age of each slot.
module mva_voice_table (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mva_pkg::voice_idx_t   rd_idx,
  output mva_pkg::voice_entry_t rd_entry,
  input  mva_pkg::table_cmd_t   cmd
);
  import mva_pkg::*;

  voice_mask_t       busy_r;
  logic [NOTE_W-1:0] note_r [VOICES];
  logic [CHAN_W-1:0] chan_r [VOICES];
  age_t              age_r  [VOICES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (cmd.set_en) begin
      busy_r[cmd.idx] <= 1'b1;
    end else if (cmd.clr_en) begin
      busy_r[cmd.idx] <= 1'b0;
    end
    // released slots keep their note, channel and age
    if (cmd.set_en) begin
      note_r[cmd.idx] <= cmd.note;
      chan_r[cmd.idx] <= cmd.channel;
      age_r[cmd.idx]  <= cmd.age;
    end
  end

  assign rd_entry.busy    = busy_r[rd_idx];
  assign rd_entry.note    = note_r[rd_idx];
  assign rd_entry.channel = chan_r[rd_idx];
  assign rd_entry.age     = age_r[rd_idx];

endmodule
